/* rtl/umpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL multi-pattern matcher package
// Shared sizes, codes, the queued item type and the ASCII case fold.
// ----------------------------------------------------------------------------
package umpm_pkg;

  localparam int NUM_PATTERNS = 8;
  localparam int PATTERN_LEN  = 32;
  // Lengths run from 0 to PATTERN_LEN + 1 (the URL length saturates there).
  localparam int LEN_W        = $clog2(PATTERN_LEN + 2);
  localparam int POS_W        = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
  localparam int SLOT_W       = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_STAR = 8'h2A;

  localparam logic [1:0] FK_ALL     = 2'd0;
  localparam logic [1:0] FK_KEYWORD = 2'd1;
  localparam logic [1:0] FK_URL     = 2'd2;
  localparam logic [1:0] FK_FILE    = 2'd3;

  localparam logic REG_FILTER_KIND     = 1'b0;
  localparam logic REG_ACTIVE_PATTERNS = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_URL
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         ch;
    logic               has_char;
    logic               last;
    logic [SLOT_W-1:0]  slot;
    logic               kind;
  } item_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

/* rtl/umpm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL matcher front end
// Accepts items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module umpm_front import umpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic              mode,
  input  logic [7:0]        char_value,
  input  logic              has_char,
  input  logic              last,
  input  logic [SLOT_W-1:0] slot,
  input  logic              pattern_kind,
  output item_t             head,
  output logic              head_valid,
  input  logic              pop
);

  item_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  item_t             cls;
  logic              push;
  logic              do_pop;

  // Items with neither a character nor an end mark do nothing and are dropped.
  always_comb begin
    cls.ch       = char_value;
    cls.has_char = has_char;
    cls.last     = last;
    cls.slot     = slot;
    cls.kind     = pattern_kind;
    if (!(has_char || last)) begin
      cls.op = OP_NONE;
    end else if (mode) begin
      cls.op = OP_URL;
    end else begin
      cls.op = OP_LOAD;
    end
  end

  assign stall      = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];
  assign push       = valid && !stall && (cls.op != OP_NONE);
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");
  a_no_pop_empty : assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !do_pop)
    else $error("pop from empty queue");
  a_count_track : assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count not advanced on push");
`endif

endmodule

/* rtl/umpm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL matcher back end
// Pattern table, per-slot shift-and and prefix tracking, result register.
// ----------------------------------------------------------------------------
module umpm_back import umpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  item_t      head,
  input  logic       head_valid,
  output logic       pop,
  input  logic [1:0] filter_kind,
  input  logic [3:0] active_patterns,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       matched
);

  // Pattern cells hold case-folded bytes; each compares against the URL byte.
  logic [7:0]       chars       [NUM_PATTERNS][PATTERN_LEN];
  logic [LEN_W-1:0] plen        [NUM_PATTERNS];
  logic             kinds       [NUM_PATTERNS];
  logic             star        [NUM_PATTERNS];
  logic [PATTERN_LEN-1:0] hits  [NUM_PATTERNS];
  logic             found       [NUM_PATTERNS];
  logic             broken      [NUM_PATTERNS];
  logic [LEN_W-1:0] url_len;
  logic [LEN_W-1:0] load_pos;

  logic [PATTERN_LEN-1:0] eq       [NUM_PATTERNS];
  logic [PATTERN_LEN-1:0] hits_next [NUM_PATTERNS];
  logic             found_next  [NUM_PATTERNS];
  logic             broken_next [NUM_PATTERNS];
  logic [LEN_W-1:0] url_len_next;
  logic [LEN_W-1:0] load_pos_next;
  logic             slot_ok     [NUM_PATTERNS];
  logic             any_ok;
  logic             match_next;
  logic             is_end;
  logic             do_url;
  logic             do_load;
  logic             store_char;
  logic [7:0]       fch;

  assign fch    = fold(head.ch);
  assign is_end = (head.op == OP_URL) && head.last;
  assign pop    = head_valid && (!is_end || !result_valid || !result_stall);
  assign do_url  = pop && (head.op == OP_URL);
  assign do_load = pop && (head.op == OP_LOAD);

  always_comb begin
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      for (int j = 0; j < PATTERN_LEN; j++) begin
        eq[s][j] = (chars[s][j] == fch);
      end
    end
  end

  // URL character step: shift-and per slot, prefix check at url_len.
  always_comb begin
    logic [LEN_W-1:0] lim;
    logic             st;
    logic [LEN_W-1:0] nm1;
    url_len_next = url_len;
    if (head.has_char && url_len < LEN_W'(PATTERN_LEN + 1)) begin
      url_len_next = url_len + 1'b1;
    end
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      st  = (plen[s] != '0) && star[s];
      lim = st ? plen[s] - 1'b1 : plen[s];
      nm1 = plen[s] - 1'b1;
      hits_next[s]   = hits[s];
      found_next[s]  = found[s];
      broken_next[s] = broken[s];
      if (head.has_char) begin
        for (int j = 0; j < PATTERN_LEN; j++) begin
          hits_next[s][j] = (LEN_W'(j) < plen[s]) && eq[s][j] &&
                            ((j == 0) ? 1'b1 : hits[s][(j == 0) ? 0 : j - 1]);
        end
        if (plen[s] != '0 && hits_next[s][nm1[POS_W-1:0]]) begin
          found_next[s] = 1'b1;
        end
        if (url_len < lim && !eq[s][url_len[POS_W-1:0]]) begin
          broken_next[s] = 1'b1;
        end
      end
    end
  end

  // Verdict from the state after the final character.
  always_comb begin
    logic st;
    any_ok = 1'b0;
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      st = (plen[s] != '0) && star[s];
      if (kinds[s]) begin
        if (broken_next[s]) begin
          slot_ok[s] = 1'b0;
        end else if (st) begin
          slot_ok[s] = (url_len_next >= plen[s] - 1'b1);
        end else begin
          slot_ok[s] = (url_len_next == plen[s]);
        end
      end else begin
        slot_ok[s] = (plen[s] == '0) || found_next[s];
      end
      if (32'(s) < 32'(active_patterns) && slot_ok[s]) begin
        any_ok = 1'b1;
      end
    end
  end

  always_comb begin
    logic st0;
    st0 = (plen[0] != '0) && star[0];
    unique case (filter_kind)
      FK_KEYWORD: match_next = (plen[0] == '0) || found_next[0];
      FK_URL: begin
        if (broken_next[0]) begin
          match_next = 1'b0;
        end else if (st0) begin
          match_next = (url_len_next >= plen[0] - 1'b1);
        end else begin
          match_next = (url_len_next == plen[0]);
        end
      end
      FK_FILE: match_next = any_ok;
      default: match_next = 1'b1;
    endcase
  end

  assign store_char    = head.has_char && (load_pos < LEN_W'(PATTERN_LEN));
  assign load_pos_next = store_char ? load_pos + 1'b1 : load_pos;

  always_ff @(posedge clk) begin
    if (do_load && store_char) begin
      chars[head.slot][load_pos[POS_W-1:0]] <= fch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        plen[s]   <= '0;
        kinds[s]  <= 1'b0;
        star[s]   <= 1'b0;
        hits[s]   <= '0;
        found[s]  <= 1'b0;
        broken[s] <= 1'b0;
      end
      url_len      <= '0;
      load_pos     <= '0;
      result_valid <= 1'b0;
      matched      <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (do_load) begin
        if (store_char) begin
          star[head.slot] <= (head.ch == CHAR_STAR);
        end
        plen[head.slot] <= load_pos_next;
        if (head.last) begin
          kinds[head.slot] <= head.kind;
          load_pos         <= '0;
        end else begin
          load_pos <= load_pos_next;
        end
      end
      if (do_url) begin
        if (head.last) begin
          for (int s = 0; s < NUM_PATTERNS; s++) begin
            hits[s]   <= '0;
            found[s]  <= 1'b0;
            broken[s] <= 1'b0;
          end
          url_len      <= '0;
          result_valid <= 1'b1;
          matched      <= match_next;
        end else begin
          for (int s = 0; s < NUM_PATTERNS; s++) begin
            hits[s]   <= hits_next[s];
            found[s]  <= found_next[s];
            broken[s] <= broken_next[s];
          end
          url_len <= url_len_next;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_url_clear : assert property (@(posedge clk) disable iff (rst)
    (do_url && head.last) |=> (url_len == '0))
    else $error("URL state not cleared at URL end");
  a_load_bound : assert property (@(posedge clk) disable iff (rst)
    load_pos <= LEN_W'(PATTERN_LEN))
    else $error("load position past pattern length");
  a_url_bound : assert property (@(posedge clk) disable iff (rst)
    url_len <= LEN_W'(PATTERN_LEN + 1))
    else $error("URL length past saturation");
  a_result_on_end : assert property (@(posedge clk) disable iff (rst)
    (do_url && head.last) |=> result_valid)
    else $error("URL end gave no result");
`endif

endmodule

/* rtl/url_multi_pattern_matcher.sv */
`timescale 1ns / 1ps
// With an empty queue, an item that ends a URL is written into the queue at its
// transfer; the result register is then loaded from the queue head.
// Throughput: one item per cycle while the queue has room; every slot compares in parallel in the back end.
// A stalled result holds back only a URL end; the four-entry queue absorbs the wait.
// Reset: synchronous, active high; clears lengths, kinds, URL state, queue and
// both registers. Pattern bytes are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// URL multi-pattern matcher with an APB register port
// Case-insensitive keyword (substring), url (exact or prefix), file (any active
// slot) or match-all filtering of a streamed URL against a loaded pattern table.
// ----------------------------------------------------------------------------
module url_multi_pattern_matcher import umpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Item channel.
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              mode,
  input  logic [7:0]        char_value,
  input  logic              has_char,
  input  logic              last,
  input  logic [SLOT_W-1:0] slot,
  input  logic              pattern_kind,
  // Result channel.
  output logic              result_valid,
  input  logic              result_stall,
  output logic              matched
);

  logic [1:0] filter_kind;
  logic [3:0] active_patterns;
  logic       reg_write;
  item_t      head;
  logic       head_valid;
  logic       pop;

  // Registers sit at byte addresses 0 and 4; bit 2 selects between them.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_kind     <= FK_ALL;
      active_patterns <= '0;
    end else if (reg_write) begin
      unique case (paddr[2])
        REG_FILTER_KIND:     filter_kind     <= pwdata[1:0];
        REG_ACTIVE_PATTERNS: active_patterns <= pwdata[3:0];
        default:             filter_kind     <= filter_kind;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FILTER_KIND:     prdata = {30'd0, filter_kind};
      REG_ACTIVE_PATTERNS: prdata = {28'd0, active_patterns};
      default:             prdata = '0;
    endcase
  end

  // The front end takes every transfer it has room for; the queue lets a
  // waiting result hold the back end without stopping the item channel until it fills.
  umpm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .valid        (item_valid),
    .stall        (item_stall),
    .mode         (mode),
    .char_value   (char_value),
    .has_char     (has_char),
    .last         (last),
    .slot         (slot),
    .pattern_kind (pattern_kind),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop)
  );

  // The back end retires one queued item per cycle, pausing only when a URL
  // end meets a result register that is still held by a stall.
  umpm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .filter_kind     (filter_kind),
    .active_patterns (active_patterns),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .matched         (matched)
  );

endmodule
